// ===== rtl/odbp_pkg.sv =====
package odbp_pkg;

  localparam int MAX_WIDTH_DEF    = 1024;
  localparam int PALETTE_SIZE_DEF = 256;
  localparam int MID_DEPTH        = 4;
  localparam int OUT_DEPTH        = 2;

  localparam int CFG_IDX_W        = 2;
  localparam int CFG_DATA_W       = 16;
  localparam int CFG_WIDTH_RST    = 1024;
  localparam int IMG_WIDTH_W      = 11;

  localparam int SUM_W            = 15;
  localparam int GREY_W           = 6;
  localparam int GREY_MUL         = 5243;
  localparam int GREY_SHIFT       = 21;
  localparam int ROW_W            = 16;
  localparam int BAND_W           = 13;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH  = 2'd0,
    REG_IMAGE_HEIGHT = 2'd1
  } cfg_reg_t;

  typedef enum logic {
    CMD_LOAD  = 1'b0,
    CMD_PIXEL = 1'b1
  } cmd_t;

  typedef struct packed {
    cmd_t              cmd;
    logic [7:0]        code;
    logic [SUM_W-1:0]  sum;
    logic [2:0]        row;
    logic              last_row;
    logic              last_col;
    logic [BAND_W-1:0] band;
  } mid_ctl_t;

  typedef struct packed {
    logic [7:0]        col_byte;
    logic [BAND_W-1:0] band;
    logic              done;
  } out_res_t;

  localparam logic [GREY_W-1:0] BAYER [8][8] = '{
    '{6'd0,  6'd32, 6'd8,  6'd40, 6'd2,  6'd34, 6'd10, 6'd42},
    '{6'd48, 6'd16, 6'd56, 6'd24, 6'd50, 6'd18, 6'd58, 6'd26},
    '{6'd12, 6'd44, 6'd4,  6'd36, 6'd14, 6'd46, 6'd6,  6'd38},
    '{6'd60, 6'd28, 6'd52, 6'd20, 6'd62, 6'd30, 6'd54, 6'd22},
    '{6'd3,  6'd35, 6'd11, 6'd43, 6'd1,  6'd33, 6'd9,  6'd41},
    '{6'd51, 6'd19, 6'd59, 6'd27, 6'd49, 6'd17, 6'd57, 6'd25},
    '{6'd15, 6'd47, 6'd7,  6'd39, 6'd13, 6'd45, 6'd5,  6'd37},
    '{6'd63, 6'd31, 6'd55, 6'd23, 6'd61, 6'd29, 6'd53, 6'd21}
  };

  function automatic logic dot(input logic [GREY_W-1:0] grey, input logic [2:0] row,
                               input logic [2:0] colm);
    return grey <= BAYER[row][colm];
  endfunction

endpackage

// ===== rtl/odbp_fifo.sv =====
module odbp_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = 4
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push_i,
  input  logic [W-1:0] data_i,
  output logic         full_o,
  input  logic         pop_i,
  output logic [W-1:0] data_o,
  output logic         empty_o
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [W-1:0]     mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full_o  = (cnt_r == CNT_W'(DEPTH));
  assign empty_o = (cnt_r == '0);
  assign data_o  = mem_r[rd_ptr_r];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= data_i;
    end
  end

endmodule

// ===== rtl/odbp_front.sv =====
module odbp_front #(
  parameter int MAX_WIDTH = odbp_pkg::MAX_WIDTH_DEF,
  parameter int CW        = $clog2(MAX_WIDTH)
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_push,
  input  logic                                in_cmd,
  input  logic [7:0]                          in_palette_slot,
  input  logic [7:0]                          in_red,
  input  logic [7:0]                          in_green,
  input  logic [7:0]                          in_blue,
  input  logic [7:0]                          in_pixel_code,
  input  logic                                cfg_valid,
  input  logic [odbp_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [odbp_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                                mid_full_i,
  output logic                                mid_push_o,
  output logic [$bits(odbp_pkg::mid_ctl_t)+CW-1:0] mid_data_o
);

  localparam int RST_W = (odbp_pkg::CFG_WIDTH_RST > MAX_WIDTH) ? MAX_WIDTH
                                                                : odbp_pkg::CFG_WIDTH_RST;

  logic [CW-1:0]                 wlast_r, wlast_nxt;
  logic [odbp_pkg::ROW_W-1:0]    hlast_r, hlast_nxt;
  logic [CW-1:0]                 cnt_r, cnt_nxt;
  logic [odbp_pkg::ROW_W-1:0]    row_r, row_nxt;
  logic [CW-1:0]                 col;
  logic                          last_col, last_row, pix_acc;
  odbp_pkg::mid_ctl_t            ctl;

  always_comb begin
    logic [31:0] wv;
    logic [31:0] hv;
    wv = 32'(cfg_data[odbp_pkg::IMG_WIDTH_W-1:0]);
    hv = 32'(cfg_data);
    if (wv == 32'd0) begin
      wv = 32'd1;
    end
    if (wv > 32'(MAX_WIDTH)) begin
      wv = 32'(MAX_WIDTH);
    end
    if (hv == 32'd0) begin
      hv = 32'd1;
    end
    wlast_nxt = wlast_r;
    hlast_nxt = hlast_r;
    if (cfg_valid && cfg_index == odbp_pkg::REG_IMAGE_WIDTH) begin
      wlast_nxt = CW'(wv - 32'd1);
    end
    if (cfg_valid && cfg_index == odbp_pkg::REG_IMAGE_HEIGHT) begin
      hlast_nxt = odbp_pkg::ROW_W'(hv - 32'd1);
    end
  end

  assign col      = (cnt_r > wlast_r) ? wlast_r : cnt_r;
  assign last_col = (col == wlast_r);
  assign last_row = (row_r >= hlast_r);

  assign mid_push_o = in_push && !mid_full_i;
  assign pix_acc    = mid_push_o && (in_cmd == odbp_pkg::CMD_PIXEL);

  always_comb begin
    ctl.cmd      = odbp_pkg::cmd_t'(in_cmd);
    ctl.code     = (in_cmd == odbp_pkg::CMD_LOAD) ? in_palette_slot : in_pixel_code;
    ctl.sum      = odbp_pkg::SUM_W'(32'd30 * 32'(in_red) + 32'd59 * 32'(in_green)
                                    + 32'd11 * 32'(in_blue));
    ctl.row      = row_r[2:0];
    ctl.last_row = last_row;
    ctl.last_col = last_col;
    ctl.band     = row_r[odbp_pkg::ROW_W-1:3];
  end

  assign mid_data_o = {ctl, col};

  always_comb begin
    cnt_nxt = cnt_r;
    row_nxt = row_r;
    if (pix_acc) begin
      if (last_col) begin
        cnt_nxt = '0;
        row_nxt = last_row ? '0 : row_r + 1'b1;
      end else begin
        cnt_nxt = col + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wlast_r <= CW'(RST_W - 1);
      hlast_r <= '0;
      cnt_r   <= '0;
      row_r   <= '0;
    end else begin
      wlast_r <= wlast_nxt;
      hlast_r <= hlast_nxt;
      cnt_r   <= cnt_nxt;
      row_r   <= row_nxt;
    end
  end

endmodule

// ===== rtl/odbp_back.sv =====
module odbp_back #(
  parameter int MAX_WIDTH    = odbp_pkg::MAX_WIDTH_DEF,
  parameter int PALETTE_SIZE = odbp_pkg::PALETTE_SIZE_DEF,
  parameter int CW           = $clog2(MAX_WIDTH),
  parameter int PW           = (PALETTE_SIZE > 1) ? $clog2(PALETTE_SIZE) : 1
) (
  input  logic                                      clk,
  input  logic                                      rst_n,
  input  logic                                      mid_empty_i,
  input  logic [$bits(odbp_pkg::mid_ctl_t)+CW-1:0]  mid_data_i,
  output logic                                      mid_pop_o,
  input  logic                                      out_full_i,
  output logic                                      out_push_o,
  output logic [$bits(odbp_pkg::out_res_t)+CW-1:0]  out_data_o
);

  localparam int MUL_W = odbp_pkg::SUM_W + $clog2(odbp_pkg::GREY_MUL + 1);
  localparam int GW    = odbp_pkg::GREY_W;

  logic [GW-1:0]      grey_mem [PALETTE_SIZE];
  logic [6:0]         band_mem [MAX_WIDTH];

  odbp_pkg::mid_ctl_t hd_ctl;
  logic [CW-1:0]      hd_col;
  logic [MUL_W-1:0]   prod;
  logic [GW-1:0]      new_grey;
  logic               slot_ok, hd_pixel;

  logic               s1_v_r, s1_v_nxt;
  odbp_pkg::mid_ctl_t s1_ctl_r;
  logic [CW-1:0]      s1_col_r;
  logic [GW-1:0]      grey_rd_r;
  logic               code_ok_r;
  logic [6:0]         band_rd_r;
  logic [GW-1:0]      grey0_r;

  logic               fwd_v_r;
  logic [CW-1:0]      fwd_col_r;
  logic [6:0]         fwd_bits_r;

  logic               s1_fire, out_now;
  logic [GW-1:0]      grey;
  logic [6:0]         prev7;
  logic [7:0]         col_byte;
  odbp_pkg::out_res_t res;

  assign {hd_ctl, hd_col} = mid_data_i;
  assign hd_pixel = (hd_ctl.cmd == odbp_pkg::CMD_PIXEL);
  assign prod     = MUL_W'(hd_ctl.sum) * MUL_W'(odbp_pkg::GREY_MUL);
  assign new_grey = prod[odbp_pkg::GREY_SHIFT +: GW];
  assign slot_ok  = ({1'b0, hd_ctl.code} < 9'(PALETTE_SIZE));

  assign out_now   = (s1_ctl_r.row == 3'd7) || s1_ctl_r.last_row;
  assign s1_fire   = s1_v_r && (!out_now || !out_full_i);
  assign mid_pop_o = !mid_empty_i && (!s1_v_r || s1_fire);

  always_comb begin
    s1_v_nxt = s1_v_r;
    if (mid_pop_o) begin
      s1_v_nxt = hd_pixel;
    end else if (s1_fire) begin
      s1_v_nxt = 1'b0;
    end
  end

  // grey palette: write on load, registered read on pixel
  always_ff @(posedge clk) begin
    if (mid_pop_o) begin
      if (!hd_pixel) begin
        if (slot_ok) begin
          grey_mem[hd_ctl.code[PW-1:0]] <= new_grey;
        end
        if (hd_ctl.code == 8'd0) begin
          grey0_r <= new_grey;
        end
      end else begin
        grey_rd_r <= grey_mem[hd_ctl.code[PW-1:0]];
        code_ok_r <= slot_ok;
        s1_ctl_r  <= hd_ctl;
        s1_col_r  <= hd_col;
      end
    end
  end

  // partial band column bits
  always_ff @(posedge clk) begin
    if (mid_pop_o && hd_pixel) begin
      band_rd_r <= band_mem[hd_col];
    end
    if (s1_fire && !out_now) begin
      band_mem[s1_col_r] <= col_byte[7:1];
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && !out_now) begin
      fwd_col_r  <= s1_col_r;
      fwd_bits_r <= col_byte[7:1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      fwd_v_r <= 1'b0;
    end else begin
      s1_v_r <= s1_v_nxt;
      if (s1_fire && !out_now) begin
        fwd_v_r <= 1'b1;
      end
    end
  end

  assign grey  = code_ok_r ? grey_rd_r : '0;
  assign prev7 = (fwd_v_r && fwd_col_r == s1_col_r) ? fwd_bits_r : band_rd_r;

  always_comb begin
    logic [7:0] pb;
    logic [2:0] j;
    pb = {prev7, 1'b0};
    for (int b = 0; b < 8; b++) begin
      j = 3'(7 - b);
      if (j < s1_ctl_r.row) begin
        col_byte[b] = pb[b];
      end else if (j == s1_ctl_r.row) begin
        col_byte[b] = odbp_pkg::dot(grey, j, s1_col_r[2:0]);
      end else begin
        col_byte[b] = out_now && odbp_pkg::dot(grey0_r, j, s1_col_r[2:0]);
      end
    end
  end

  always_comb begin
    res.col_byte = col_byte;
    res.band     = s1_ctl_r.band;
    res.done     = s1_ctl_r.last_col;
  end

  assign out_push_o = s1_fire && out_now;
  assign out_data_o = {res, s1_col_r};

`ifndef SYNTHESIS
  assert property (@(posedge clk) disable iff (!rst_n) out_push_o |-> !out_full_i)
    else $error("result pushed into full output queue");
  assert property (@(posedge clk) disable iff (!rst_n) mid_pop_o |-> !mid_empty_i)
    else $error("request popped from empty queue");
  assert property (@(posedge clk) disable iff (!rst_n)
                   s1_v_r && !s1_fire |=> s1_v_r && $stable(s1_col_r))
    else $error("stalled pixel lost its column");
  assert property (@(posedge clk) disable iff (!rst_n)
                   s1_fire && !out_now |=> fwd_v_r && fwd_col_r == $past(s1_col_r))
    else $error("band bit forward not updated");
`endif

endmodule

// ===== rtl/ordered_dither_band_packer_top.sv =====
// Path: a pixel request goes via the request queue, memory read stage and output queue to
// the out_ ports, later if out_pop stalls. Throughput: one request (palette load or
// pixel) per cycle unless a full output queue stalls; the band-bits memory takes one
// read and one write each cycle, with the previous write forwarded to a same-column read.
// Reset: synchronous rst_n clears counters, queues, image_width to 1024, image_height
// to 1; palette and band-bits memories are not cleared and must be written before use.
module ordered_dither_band_packer_top #(
  parameter int MAX_WIDTH    = odbp_pkg::MAX_WIDTH_DEF,
  parameter int PALETTE_SIZE = odbp_pkg::PALETTE_SIZE_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_push,
  output logic                            in_full,
  input  logic                            in_cmd,
  input  logic [7:0]                      in_palette_slot,
  input  logic [7:0]                      in_red,
  input  logic [7:0]                      in_green,
  input  logic [7:0]                      in_blue,
  input  logic [7:0]                      in_pixel_code,
  output logic                            out_empty,
  input  logic                            out_pop,
  output logic [7:0]                      out_column_byte,
  output logic [$clog2(MAX_WIDTH)-1:0]    out_column_number,
  output logic [odbp_pkg::BAND_W-1:0]     out_band_number,
  output logic                            out_band_done,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [odbp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [odbp_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int PW    = (PALETTE_SIZE > 1) ? $clog2(PALETTE_SIZE) : 1;
  localparam int MID_W = $bits(odbp_pkg::mid_ctl_t) + CW;
  localparam int OUT_W = $bits(odbp_pkg::out_res_t) + CW;

  logic               mid_push, mid_full, mid_pop, mid_empty;
  logic [MID_W-1:0]   mid_wdata, mid_rdata;
  logic               out_push, out_full;
  logic [OUT_W-1:0]   out_wdata, out_rdata;
  odbp_pkg::out_res_t out_res;

  assign cfg_ready = 1'b1;
  assign in_full   = mid_full;

  odbp_front #(
    .MAX_WIDTH (MAX_WIDTH),
    .CW        (CW)
  ) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_push         (in_push),
    .in_cmd          (in_cmd),
    .in_palette_slot (in_palette_slot),
    .in_red          (in_red),
    .in_green        (in_green),
    .in_blue         (in_blue),
    .in_pixel_code   (in_pixel_code),
    .cfg_valid       (cfg_valid),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .mid_full_i      (mid_full),
    .mid_push_o      (mid_push),
    .mid_data_o      (mid_wdata)
  );

  odbp_fifo #(
    .W     (MID_W),
    .DEPTH (odbp_pkg::MID_DEPTH)
  ) u_mid_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .push_i  (mid_push),
    .data_i  (mid_wdata),
    .full_o  (mid_full),
    .pop_i   (mid_pop),
    .data_o  (mid_rdata),
    .empty_o (mid_empty)
  );

  odbp_back #(
    .MAX_WIDTH    (MAX_WIDTH),
    .PALETTE_SIZE (PALETTE_SIZE),
    .CW           (CW),
    .PW           (PW)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .mid_empty_i (mid_empty),
    .mid_data_i  (mid_rdata),
    .mid_pop_o   (mid_pop),
    .out_full_i  (out_full),
    .out_push_o  (out_push),
    .out_data_o  (out_wdata)
  );

  odbp_fifo #(
    .W     (OUT_W),
    .DEPTH (odbp_pkg::OUT_DEPTH)
  ) u_out_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .push_i  (out_push),
    .data_i  (out_wdata),
    .full_o  (out_full),
    .pop_i   (out_pop),
    .data_o  (out_rdata),
    .empty_o (out_empty)
  );

  assign {out_res, out_column_number} = out_rdata;
  assign out_column_byte = out_res.col_byte;
  assign out_band_number = out_res.band;
  assign out_band_done   = out_res.done;

endmodule

// ===== verif/tb_ordered_dither_band_packer_top.sv =====
module tb_ordered_dither_band_packer_top;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int LONG_HOLD = 300;
  localparam int REPORT_LIMIT = 10;
  localparam int RANDOM_PIXELS = 200;
  localparam logic [odbp_pkg::CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [odbp_pkg::CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

  localparam int THRESHOLD [8][8] = '{
    '{ 0, 32,  8, 40,  2, 34, 10, 42},
    '{48, 16, 56, 24, 50, 18, 58, 26},
    '{12, 44,  4, 36, 14, 46,  6, 38},
    '{60, 28, 52, 20, 62, 30, 54, 22},
    '{ 3, 35, 11, 43,  1, 33,  9, 41},
    '{51, 19, 59, 27, 49, 17, 57, 25},
    '{15, 47,  7, 39, 13, 45,  5, 37},
    '{63, 31, 55, 23, 61, 29, 53, 21}
  };

  typedef struct {
    odbp_pkg::cmd_t cmd;
    logic [7:0]     slot;
    logic [7:0]     red;
    logic [7:0]     green;
    logic [7:0]     blue;
    logic [7:0]     code;
  } request_t;

  typedef struct packed {
    logic [7:0]  dots;
    logic [9:0]  col;
    logic [12:0] band;
    logic        done;
  } column_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_push = 1'b0;
  logic in_full;
  logic in_cmd = 1'b0;
  logic [7:0] in_palette_slot = 8'h00;
  logic [7:0] in_red = 8'h00;
  logic [7:0] in_green = 8'h00;
  logic [7:0] in_blue = 8'h00;
  logic [7:0] in_pixel_code = 8'h00;
  logic out_empty;
  logic out_pop = 1'b0;
  logic [7:0] out_column_byte;
  logic [9:0] out_column_number;
  logic [odbp_pkg::BAND_W-1:0] out_band_number;
  logic out_band_done;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [odbp_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [odbp_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  ordered_dither_band_packer_top dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_push(in_push),
    .in_full(in_full),
    .in_cmd(in_cmd),
    .in_palette_slot(in_palette_slot),
    .in_red(in_red),
    .in_green(in_green),
    .in_blue(in_blue),
    .in_pixel_code(in_pixel_code),
    .out_empty(out_empty),
    .out_pop(out_pop),
    .out_column_byte(out_column_byte),
    .out_column_number(out_column_number),
    .out_band_number(out_band_number),
    .out_band_done(out_band_done),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // shadow of the block
  logic [5:0] grey_mem [256];
  logic [6:0] dots_mem [1024];
  int col_pos = 0;
  int row_pos = 0;
  logic [10:0] width_reg = 11'd1024;
  logic [15:0] height_reg = 16'd1;
  column_t due_columns [$];

  request_t in_stream [$];
  request_t next_req;
  logic [7:0] loaded_slots [$];
  bit slot_loaded [256];
  int gap_spans [3] = '{0, 3, 14};

  bit req_taken = 1'b0;
  bit res_taken = 1'b0;
  bit cfg_taken = 1'b0;
  int tx_gap_max = 14;
  int rx_gap_max = 14;
  int send_wait = 0;
  int pop_wait = 0;
  int stall_orders = 0;
  int stall_done = 0;
  int queued_count = 0;
  int fed_count = 0;
  int pixels_seen = 0;
  int loads_seen = 0;
  int columns_checked = 0;
  int mismatches = 0;
  int settings_used = 0;
  int unsigned cycle_count = 0;
  column_t got;
  column_t want;

  always #4 clk = ~clk;

  function automatic int cols_of(input logic [10:0] w);
    if (w == 0) return 1;
    if (w > odbp_pkg::MAX_WIDTH_DEF) return odbp_pkg::MAX_WIDTH_DEF;
    return int'(w);
  endfunction

  function automatic int rows_of(input logic [15:0] h);
    return (h == 0) ? 1 : int'(h);
  endfunction

  function automatic logic [7:0] dot_at(input logic [5:0] grey, input int r, input int c);
    return (int'(grey) <= THRESHOLD[r][c % 8]) ? (8'h80 >> r) : 8'h00;
  endfunction

  function automatic logic [7:0] shade();
    case ($urandom_range(0, 3))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic dither_request(input odbp_pkg::cmd_t cmd, input logic [7:0] slot,
                                input logic [7:0] red, input logic [7:0] green,
                                input logic [7:0] blue, input logic [7:0] code);
    int w, h, c, r, j;
    logic [7:0] dots;
    logic last_row, last_col;
    if (cmd == odbp_pkg::CMD_LOAD) begin
      grey_mem[slot] = 6'((30 * int'(red) + 59 * int'(green) + 11 * int'(blue)) / 400);
      loads_seen++;
    end else begin
      pixels_seen++;
      w = cols_of(width_reg);
      h = rows_of(height_reg);
      c = (col_pos >= w) ? w - 1 : col_pos;
      r = row_pos % 8;
      last_row = row_pos >= h - 1;
      last_col = c >= w - 1;
      dots = dot_at(grey_mem[code], r, c) | ({dots_mem[c], 1'b0} & 8'(16'hFF00 >> r));
      if (r == 7 || last_row) begin
        // pad the rest of the band with palette entry 0
        for (j = r + 1; j < 8; j++) dots |= dot_at(grey_mem[0], j, c);
        due_columns.push_back('{dots, 10'(c), 13'(row_pos >> 3), last_col});
      end else begin
        dots_mem[c] = dots[7:1];
      end
      if (last_col) begin
        col_pos = 0;
        row_pos = last_row ? 0 : (row_pos + 1) % 65536;
      end else begin
        col_pos = c + 1;
      end
    end
  endtask

  always @(posedge clk) begin
    req_taken = rst_n && in_push && !in_full;
    res_taken = rst_n && out_pop && !out_empty;
    cfg_taken = rst_n && cfg_valid && cfg_ready;
    cycle_count++;
    if (cfg_taken) begin
      if (cfg_index == odbp_pkg::REG_IMAGE_WIDTH) width_reg = cfg_data[10:0];
      else if (cfg_index == odbp_pkg::REG_IMAGE_HEIGHT) height_reg = cfg_data;
    end
    if (req_taken) begin
      fed_count++;
      dither_request(odbp_pkg::cmd_t'(in_cmd), in_palette_slot, in_red, in_green, in_blue,
                     in_pixel_code);
    end
    if (res_taken) begin
      got = '{out_column_byte, out_column_number, out_band_number, out_band_done};
      if (due_columns.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("unexpected column: byte %h col %0d band %0d done %b",
                   got.dots, got.col, got.band, got.done);
      end else begin
        want = due_columns.pop_front();
        columns_checked++;
        if (got !== want) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT)
            $display({"column mismatch: expected byte %h col %0d band %0d done %b,",
                      " got byte %h col %0d band %0d done %b"},
                     want.dots, want.col, want.band, want.done,
                     got.dots, got.col, got.band, got.done);
        end
      end
    end
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("Mismatches found");
      $finish;
    end
  end

  always @(negedge clk) begin
    if (rst_n && (!in_push || req_taken)) begin
      if (send_wait > 0) begin
        send_wait--;
        in_push <= 1'b0;
      end else if (in_stream.size() != 0) begin
        next_req = in_stream.pop_front();
        in_cmd <= next_req.cmd;
        in_palette_slot <= next_req.slot;
        in_red <= next_req.red;
        in_green <= next_req.green;
        in_blue <= next_req.blue;
        in_pixel_code <= next_req.code;
        in_push <= 1'b1;
        send_wait = $urandom_range(0, tx_gap_max);
      end else begin
        in_push <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (rst_n) begin
      if (res_taken) pop_wait = $urandom_range(0, rx_gap_max);
      if (stall_done != stall_orders) begin
        stall_done++;
        pop_wait = LONG_HOLD;
      end
      if (pop_wait > 0) begin
        pop_wait--;
        out_pop <= 1'b0;
      end else begin
        out_pop <= 1'b1;
      end
    end
  end

  task automatic write_reg(input logic [odbp_pkg::CFG_IDX_W-1:0] idx,
                           input logic [odbp_pkg::CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(negedge clk); while (!cfg_taken);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_image(input logic [15:0] w, input logic [15:0] h);
    write_reg(odbp_pkg::REG_IMAGE_WIDTH, w);
    write_reg(odbp_pkg::REG_IMAGE_HEIGHT, h);
    settings_used++;
  endtask

  task automatic queue_load(input logic [7:0] slot, input logic [7:0] red,
                            input logic [7:0] green, input logic [7:0] blue);
    in_stream.push_back('{odbp_pkg::CMD_LOAD, slot, red, green, blue, 8'($urandom)});
    queued_count++;
    if (!slot_loaded[slot]) begin
      slot_loaded[slot] = 1'b1;
      loaded_slots.push_back(slot);
    end
  endtask

  task automatic queue_pixel(input logic [7:0] code);
    in_stream.push_back('{odbp_pkg::CMD_PIXEL, 8'($urandom), 8'($urandom), 8'($urandom),
                          8'($urandom), code});
    queued_count++;
  endtask

  task automatic queue_rows(input int rows, input int cols);
    repeat (rows * cols) begin
      if ($urandom_range(0, 7) == 0)
        queue_load(8'($urandom_range(0, 255)), shade(), shade(), shade());
      queue_pixel(loaded_slots[$urandom_range(0, loaded_slots.size() - 1)]);
    end
  endtask

  task automatic wait_drained();
    do @(negedge clk); while (fed_count != queued_count || due_columns.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  initial begin
    int w, hgt, rows, i;
    int random_pixels;
    logic [7:0] first_codes [6];
    first_codes = '{8'd0, 8'd255, 8'd1, 8'd2, 8'd3, 8'd4};
    random_pixels = 0;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;

    write_reg(REG_SPARE_2, 16'hFFFF);
    write_reg(REG_SPARE_3, 16'h5A5A);
    // width 0 and height 0: every pixel is a whole image
    set_image(16'd0, 16'd0);
    queue_load(8'd0, 8'd128, 8'd128, 8'd128);
    queue_load(8'd255, 8'd255, 8'd255, 8'd255);
    queue_load(8'd1, 8'd0, 8'd0, 8'd0);
    queue_load(8'd2, 8'd255, 8'd0, 8'd0);
    queue_load(8'd3, 8'd0, 8'd255, 8'd0);
    queue_load(8'd4, 8'd0, 8'd0, 8'd255);
    for (i = 0; i < 4; i++) queue_pixel(first_codes[i]);
    wait_drained();

    set_image(16'd2, 16'd9);
    for (i = 0; i < 18; i++) queue_pixel(first_codes[i % 6]);
    wait_drained();

    // hold the receiver off while requests keep coming
    tx_gap_max = 0;
    rx_gap_max = 0;
    set_image(16'd5, 16'd1);
    stall_orders++;
    queue_rows(12, 5);
    wait_drained();
    queue_rows(4, 5);
    wait_drained();

    tx_gap_max = 14;
    rx_gap_max = 14;
    set_image(16'hF803, 16'hFFFF);
    queue_rows(16, 3);
    wait_drained();
    write_reg(odbp_pkg::REG_IMAGE_HEIGHT, 16'd1);
    queue_rows(1, 3);
    wait_drained();

    tx_gap_max = 3;
    rx_gap_max = 3;
    set_image(16'd1700, 16'd1);
    queue_rows(1, 1024);
    wait_drained();

    while (random_pixels < RANDOM_PIXELS) begin
      w = ($urandom_range(0, 4) == 0) ? $urandom_range(13, 64) : $urandom_range(0, 12);
      hgt = (w > 12) ? $urandom_range(0, 4) : $urandom_range(0, 20);
      tx_gap_max = gap_spans[$urandom_range(0, 2)];
      rx_gap_max = gap_spans[$urandom_range(0, 2)];
      set_image(16'(w) | ($urandom_range(0, 1) ? 16'hF800 : 16'h0000), 16'(hgt));
      rows = rows_of(16'(hgt)) * $urandom_range(1, 2);
      queue_rows(rows, cols_of(11'(w)));
      random_pixels += rows * cols_of(11'(w));
      wait_drained();
    end

    $display("dithered %0d pixels with %0d palette loads under %0d image settings",
             pixels_seen, loads_seen, settings_used);
    $display("checked %0d column bytes, widths 1..1024, heights up to 65535, %0d mismatches",
             columns_checked, mismatches);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/odbp_pkg.sv
rtl/odbp_fifo.sv
rtl/odbp_front.sv
rtl/odbp_back.sv
rtl/ordered_dither_band_packer_top.sv
verif/tb_ordered_dither_band_packer_top.sv
